// ===== rtl/bamp_pkg.sv =====
// ----------------------------------------------------------------------------
// bamp_pkg: shared types and constants for the bearer auth message parser
// Holds the channel payload structs, the parse state record, phase codes,
// keyword byte tables and the register map of the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

package bamp_pkg;

	// Input transaction payload
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	// Output transaction payload
	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] byte_kind;
		logic       message_end;
		logic [1:0] status;
	} out_item_t;

	// Parse state carried from byte to byte
	typedef struct packed {
		logic [3:0] phase;
		logic [3:0] match_pos;
		logic       is_bearer;
		logic       user_found;
		logic       token_found;
	} parse_state_t;

	// Parse phases
	localparam logic [3:0] PH_PREFIX   = 4'd0;
	localparam logic [3:0] PH_XO_USER  = 4'd1;
	localparam logic [3:0] PH_XO_AUTH  = 4'd2;
	localparam logic [3:0] PH_XO_TOKEN = 4'd3;
	localparam logic [3:0] PH_DONE     = 4'd4;
	localparam logic [3:0] PH_FAIL     = 4'd5;
	localparam logic [3:0] PH_OB_A     = 4'd6;
	localparam logic [3:0] PH_OB_USER  = 4'd7;
	localparam logic [3:0] PH_OB_FIELD = 4'd8;
	localparam logic [3:0] PH_OB_SKIP  = 4'd9;
	localparam logic [3:0] PH_OB_TOKEN = 4'd10;

	localparam parse_state_t PARSE_RESET = '{
		phase:       PH_PREFIX,
		match_pos:   4'd0,
		is_bearer:   1'b0,
		user_found:  1'b0,
		token_found: 1'b0
	};

	// Byte kinds
	localparam logic [1:0] KIND_OTHER = 2'd0;
	localparam logic [1:0] KIND_USER  = 2'd1;
	localparam logic [1:0] KIND_TOKEN = 2'd2;

	// Verdict codes
	localparam logic [1:0] ST_PENDING = 2'd0;
	localparam logic [1:0] ST_OK      = 2'd1;
	localparam logic [1:0] ST_BAD     = 2'd2;
	localparam logic [1:0] ST_UNAVAIL = 2'd3;

	// Special bytes
	localparam logic [7:0] SEP_BYTE   = 8'h01;
	localparam logic [7:0] COMMA_BYTE = 8'h2C;
	localparam logic [7:0] CH_U       = 8'h75;
	localparam logic [7:0] CH_N       = 8'h6E;

	// Keyword lengths
	localparam logic [3:0] AUTH_LEN  = 4'd12;
	localparam logic [3:0] XO_KW_LEN = 4'd5;
	localparam logic [3:0] GS2_LEN   = 4'd2;
	localparam logic [3:0] AEQ_LEN   = 4'd2;

	// Configuration port
	localparam int unsigned CFG_AW = 3;
	localparam int unsigned CFG_DW = 32;
	localparam logic REG_MECH_EN = 1'b0;

	// "auth=Bearer "
	function automatic logic [7:0] kw_auth(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'h61;
			4'd1:    c = 8'h75;
			4'd2:    c = 8'h74;
			4'd3:    c = 8'h68;
			4'd4:    c = 8'h3D;
			4'd5:    c = 8'h42;
			4'd6:    c = 8'h65;
			4'd7:    c = 8'h61;
			4'd8:    c = 8'h72;
			4'd9:    c = 8'h65;
			4'd10:   c = 8'h72;
			4'd11:   c = 8'h20;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// "user="
	function automatic logic [7:0] kw_user(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'h75;
			4'd1:    c = 8'h73;
			4'd2:    c = 8'h65;
			4'd3:    c = 8'h72;
			4'd4:    c = 8'h3D;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// "n,"
	function automatic logic [7:0] kw_gs2(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = CH_N;
			4'd1:    c = COMMA_BYTE;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// "a="
	function automatic logic [7:0] kw_aeq(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'h61;
			4'd1:    c = 8'h3D;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/bamp_step.sv =====
// ----------------------------------------------------------------------------
// bamp_step: one-byte parse step
// Given the current parse state and one message byte, computes the byte tag,
// the verdict for a final byte and the parse state for the next byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bamp_step (
	input  wire bamp_pkg::parse_state_t cur,
	input  wire logic [7:0]             data_byte,
	input  wire logic                   last_byte,
	input  wire logic                   mech_en,
	output bamp_pkg::parse_state_t      nxt,
	output logic [1:0]                  byte_kind,
	output logic [1:0]                  status
);

	logic [3:0] mp_inc;
	logic       auth_hit;
	logic       user_hit;
	logic       gs2_hit;
	logic       aeq_hit;
	logic       is_sep;
	bamp_pkg::parse_state_t adv;
	logic [1:0] kind_raw;

	// Keyword compares at the current match position
	assign mp_inc   = cur.match_pos + 4'd1;
	assign auth_hit = (cur.match_pos < bamp_pkg::AUTH_LEN) &&
		(data_byte == bamp_pkg::kw_auth(cur.match_pos));
	assign user_hit = (cur.match_pos < bamp_pkg::XO_KW_LEN) &&
		(data_byte == bamp_pkg::kw_user(cur.match_pos));
	assign gs2_hit  = (cur.match_pos < bamp_pkg::GS2_LEN) &&
		(data_byte == bamp_pkg::kw_gs2(cur.match_pos));
	assign aeq_hit  = (cur.match_pos < bamp_pkg::AEQ_LEN) &&
		(data_byte == bamp_pkg::kw_aeq(cur.match_pos));
	assign is_sep   = (data_byte == bamp_pkg::SEP_BYTE);

	// Advance the phase machine by one byte
	always_comb begin
		adv      = cur;
		kind_raw = bamp_pkg::KIND_OTHER;
		case (cur.phase)
			bamp_pkg::PH_PREFIX: begin
				if (cur.match_pos == 4'd0) begin
					if (data_byte == bamp_pkg::CH_U) begin
						adv.is_bearer = 1'b0;
						adv.match_pos = 4'd1;
					end else if (data_byte == bamp_pkg::CH_N) begin
						adv.is_bearer = 1'b1;
						adv.match_pos = 4'd1;
					end else begin
						adv.phase = bamp_pkg::PH_FAIL;
					end
				end else if (cur.is_bearer) begin
					if (!gs2_hit) begin
						adv.phase = bamp_pkg::PH_FAIL;
					end else if (mp_inc == bamp_pkg::GS2_LEN) begin
						adv.phase     = bamp_pkg::PH_OB_A;
						adv.match_pos = 4'd0;
					end else begin
						adv.match_pos = mp_inc;
					end
				end else begin
					if (!user_hit) begin
						adv.phase = bamp_pkg::PH_FAIL;
					end else if (mp_inc == bamp_pkg::XO_KW_LEN) begin
						adv.phase     = bamp_pkg::PH_XO_USER;
						adv.match_pos = 4'd0;
					end else begin
						adv.match_pos = mp_inc;
					end
				end
			end
			bamp_pkg::PH_XO_USER: begin
				if (is_sep) begin
					adv.user_found = 1'b1;
					adv.phase      = bamp_pkg::PH_XO_AUTH;
					adv.match_pos  = 4'd0;
				end else begin
					kind_raw = bamp_pkg::KIND_USER;
				end
			end
			bamp_pkg::PH_XO_AUTH: begin
				if (!auth_hit) begin
					adv.phase = bamp_pkg::PH_FAIL;
				end else if (mp_inc == bamp_pkg::AUTH_LEN) begin
					adv.phase     = bamp_pkg::PH_XO_TOKEN;
					adv.match_pos = 4'd0;
				end else begin
					adv.match_pos = mp_inc;
				end
			end
			bamp_pkg::PH_XO_TOKEN: begin
				if (is_sep) begin
					adv.token_found = 1'b1;
					adv.phase       = bamp_pkg::PH_DONE;
				end else begin
					kind_raw = bamp_pkg::KIND_TOKEN;
				end
			end
			bamp_pkg::PH_OB_A: begin
				if (!aeq_hit) begin
					adv.phase = bamp_pkg::PH_FAIL;
				end else if (mp_inc == bamp_pkg::AEQ_LEN) begin
					adv.phase     = bamp_pkg::PH_OB_USER;
					adv.match_pos = 4'd0;
				end else begin
					adv.match_pos = mp_inc;
				end
			end
			bamp_pkg::PH_OB_USER: begin
				if (data_byte == bamp_pkg::COMMA_BYTE) begin
					adv.user_found = 1'b1;
					adv.phase      = bamp_pkg::PH_OB_FIELD;
					adv.match_pos  = 4'd0;
				end else begin
					kind_raw = bamp_pkg::KIND_USER;
				end
			end
			bamp_pkg::PH_OB_FIELD: begin
				if (auth_hit) begin
					if (mp_inc == bamp_pkg::AUTH_LEN) begin
						adv.token_found = 1'b1;
						adv.phase       = bamp_pkg::PH_OB_TOKEN;
						adv.match_pos   = 4'd0;
					end else begin
						adv.match_pos = mp_inc;
					end
				end else begin
					// a separator that breaks the match opens a new field
					adv.match_pos = 4'd0;
					adv.phase     = is_sep ? bamp_pkg::PH_OB_FIELD : bamp_pkg::PH_OB_SKIP;
				end
			end
			bamp_pkg::PH_OB_SKIP: begin
				if (is_sep) begin
					adv.phase     = bamp_pkg::PH_OB_FIELD;
					adv.match_pos = 4'd0;
				end
			end
			bamp_pkg::PH_OB_TOKEN: begin
				if (is_sep) begin
					adv.phase = bamp_pkg::PH_DONE;
				end else begin
					kind_raw = bamp_pkg::KIND_TOKEN;
				end
			end
			bamp_pkg::PH_DONE, bamp_pkg::PH_FAIL: begin
				adv = cur;
			end
			default: begin
				adv.phase = bamp_pkg::PH_FAIL;
			end
		endcase
	end

	// Mask tags when disabled, give the verdict and restart on the final byte
	always_comb begin
		byte_kind = mech_en ? kind_raw : bamp_pkg::KIND_OTHER;
		status    = bamp_pkg::ST_PENDING;
		nxt       = adv;
		if (last_byte) begin
			if (!mech_en) begin
				status = bamp_pkg::ST_UNAVAIL;
			end else if (adv.user_found && adv.token_found) begin
				status = bamp_pkg::ST_OK;
			end else begin
				status = bamp_pkg::ST_BAD;
			end
			nxt = bamp_pkg::PARSE_RESET;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bearer_auth_message_parser.sv =====
// ----------------------------------------------------------------------------
// bearer_auth_message_parser: XOAUTH2 / OAUTHBEARER client message parser
// Tags each byte of a client authentication message as user name, token or
// framing, and reports the verdict with the final byte.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid / in_stall / in_data): one message byte per
//     transaction, last_byte set on the final byte of each message.
//   out channel (out_valid / out_stall / out_data): exactly one transaction
//     per input byte, in order, carrying the byte, its tag and, on the final
//     byte, the verdict (ok, bad_auth, or unavailable when disabled).
//   APB port: register 0 at byte address 0, bit 0 = mechanism enabled.
//     Write it only while no message is in flight.
// The byte lands in the input register, and the parse step result is then
// loaded into the output register when the output is not stalled.
// Throughput is one byte per cycle while the output is not stalled; the parse
// state register feeds back through the combinational step logic.
// A stall on the output holds the output register and the input register;
// in_stall rises only once both are full.
// Reset empties both registers, clears the parse state and disables the
// mechanism.
// ----------------------------------------------------------------------------
`default_nettype none

module bearer_auth_message_parser (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input byte channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire bamp_pkg::in_item_t            in_data,
	// output byte channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output bamp_pkg::out_item_t                out_data,
	// configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bamp_pkg::CFG_AW-1:0]   paddr,
	input  wire logic [bamp_pkg::CFG_DW-1:0]   pwdata,
	output logic [bamp_pkg::CFG_DW-1:0]        prdata,
	output logic                               pready
);

	logic                   mech_en_q;
	bamp_pkg::parse_state_t parse_q;
	bamp_pkg::parse_state_t parse_nxt;
	logic                   in_valid_s1;
	bamp_pkg::in_item_t     in_s1;
	logic                   out_valid_s2;
	bamp_pkg::out_item_t    out_s2;
	logic [1:0]             step_kind;
	logic [1:0]             step_status;
	logic                   adv;
	logic                   reg_sel;

	// Configuration register
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == bamp_pkg::REG_MECH_EN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mech_en_q <= 1'b0;
		end else if (psel && penable && pwrite && reg_sel) begin
			mech_en_q <= pwdata[0];
		end
	end

	assign prdata = reg_sel ? {{(bamp_pkg::CFG_DW-1){1'b0}}, mech_en_q} : '0;

	// Pipeline flow control
	assign adv      = !out_valid_s2 || !out_stall;
	assign in_stall = in_valid_s1 && !adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_s1 <= in_data;
		end
	end

	// Parse one byte
	bamp_step u_step (
		.cur       (parse_q),
		.data_byte (in_s1.data_byte),
		.last_byte (in_s1.last_byte),
		.mech_en   (mech_en_q),
		.nxt       (parse_nxt),
		.byte_kind (step_kind),
		.status    (step_status)
	);

	// Parse state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_q      <= bamp_pkg::PARSE_RESET;
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= in_valid_s1;
			if (in_valid_s1) begin
				parse_q <= parse_nxt;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (adv && in_valid_s1) begin
			out_s2.out_byte    <= in_s1.data_byte;
			out_s2.byte_kind   <= step_kind;
			out_s2.message_end <= in_s1.last_byte;
			out_s2.status      <= step_status;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_data  = out_s2;

`ifndef NO_ASSERTIONS
	// Input side only stalls when the input register is full
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> in_valid_s1)
		else $error("in_stall raised with empty input register");

	// Parse state restarts after a final byte is processed
	a_restart_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && in_valid_s1 && in_s1.last_byte) |=> (parse_q == bamp_pkg::PARSE_RESET))
		else $error("parse state not cleared after final byte");

	// Verdict appears only with the final byte
	a_status_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && !out_s2.message_end) |-> (out_s2.status == bamp_pkg::ST_PENDING))
		else $error("status given before message end");

	// Disabled mechanism: no tags, verdict unavailable
	a_disabled_output: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && !mech_en_q) |->
			((out_s2.byte_kind == bamp_pkg::KIND_OTHER) &&
			(!out_s2.message_end || (out_s2.status == bamp_pkg::ST_UNAVAIL))))
		else $error("output tagged while mechanism disabled");
`endif

endmodule

`default_nettype wire
